// ===== design/vpps_pkg.sv =====
package vpps_pkg;

    // request kinds
    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_BUS   = 1'b1
    } vpps_req_kind_t;

    // result kinds
    typedef enum logic {
        KIND_BEAM = 1'b0,
        KIND_MEM  = 1'b1
    } vpps_res_kind_t;

    // control byte commands, bits 7:6
    typedef enum logic [1:0] {
        CMD_PEN_SEL = 2'b00,
        CMD_PEN_SET = 2'b01,
        CMD_MODE    = 2'b10,
        CMD_NONE    = 2'b11
    } vpps_cmd_t;

    localparam logic [1:0] MODE_TWO_BIT = 2'd1;
    localparam logic [2:0] PHASE_FIRST  = 3'd0;
    localparam logic [2:0] PHASE_SECOND = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] io_data;
        logic       vsync_in;
        logic       hsync_in;
        logic       display_enable;
        logic [7:0] vram_byte_first;
        logic [7:0] vram_byte_second;
    } vpps_req_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] pixel_color;
        logic        hsync_out;
        logic        vsync_out;
        logic        lower_rom_enabled;
        logic        upper_rom_enabled;
    } vpps_res_t;

    // fixed hardware color table, ARGB
    function automatic logic [31:0] hw_color(input logic [4:0] idx);
        logic [31:0] c;
        case (idx)
            5'd0:  c = 32'hff6B7D6E;
            5'd1:  c = 32'hff6D7D6E;
            5'd2:  c = 32'hff6BF300;
            5'd3:  c = 32'hff6DF3F3;
            5'd4:  c = 32'hff6B0200;
            5'd5:  c = 32'hff6802F0;
            5'd6:  c = 32'hff687800;
            5'd7:  c = 32'hff6B7DF3;
            5'd8:  c = 32'hff6802F3;
            5'd9:  c = 32'hff6BF3F3;
            5'd10: c = 32'hff0DF3F3;
            5'd11: c = 32'hffF9F3FF;
            5'd12: c = 32'hff0605F3;
            5'd13: c = 32'hffF402F3;
            5'd14: c = 32'hff0D7DF3;
            5'd15: c = 32'hffF980FA;
            5'd16: c = 32'hff680200;
            5'd17: c = 32'hff6BF302;
            5'd18: c = 32'hff01F002;
            5'd19: c = 32'hffF2F30F;
            5'd20: c = 32'hff010200;
            5'd21: c = 32'hffF4020C;
            5'd22: c = 32'hff017802;
            5'd23: c = 32'hffF47B0C;
            5'd24: c = 32'hff680269;
            5'd25: c = 32'hff6BF371;
            5'd26: c = 32'hff04F571;
            5'd27: c = 32'hffF4F371;
            5'd28: c = 32'hff01026C;
            5'd29: c = 32'hffF2026C;
            5'd30: c = 32'hff017B6E;
            default: c = 32'hffF67B6E;
        endcase
        return c;
    endfunction

endpackage

// ===== design/vpps_stream_if.sv =====
interface vpps_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== design/vpps_out_buf.sv =====
module vpps_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vpps_pkg::vpps_res_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output vpps_pkg::vpps_res_t out_data
);
    import vpps_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    vpps_res_t out_data_reg;
    vpps_res_t skid_data_reg;
    logic      take;

    assign take      = out_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_reg  <= push_data;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a push never lands on a full skid entry
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("transaction pushed into full buffer");

    // a waiting skid result moves forward once the output is taken
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && take) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry did not drain");

endmodule

// ===== design/video_pixel_palette_serializer.sv =====
// Each result is registered in the output register, or in the skid entry.
// Throughput: one transaction per cycle while the skid entry is empty;
// decode, pen table and color table lookups precede the output register.
// A skid entry behind the output register keeps input ready for one stall.
// Reset (async, active low) clears phase, latched byte, mode, selected pen,
// pen table, border, held color and the output buffer.
module video_pixel_palette_serializer (
    input logic           clk,
    input logic           rst_n,
    vpps_stream_if.sink   req,
    vpps_stream_if.source res
);
    import vpps_pkg::*;

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [7:0]  latched_reg;
    logic [7:0]  latched_next;
    logic [1:0]  mode_reg;
    logic [4:0]  chosen_pen_reg;
    logic [4:0]  pen_colors_reg [16];
    logic [4:0]  border_reg;
    logic [31:0] held_reg;
    logic [31:0] held_next;

    logic        accept;
    logic        buf_full;
    logic        push;
    vpps_res_t   push_data;
    vpps_cmd_t   cmd;
    logic [1:0]  sub;
    logic [3:0]  pen;

    assign req.ready = !buf_full;
    assign accept    = req.valid && req.ready;
    assign cmd       = vpps_cmd_t'(req.payload.io_data[7:6]);
    assign sub       = phase_reg[1:0];

    // byte latch at the two load phases
    always_comb
    begin
        if (phase_reg == PHASE_FIRST)
            latched_next = req.payload.vram_byte_first;
        else if (phase_reg == PHASE_SECOND)
            latched_next = req.payload.vram_byte_second;
        else
            latched_next = latched_reg;
    end

    // pen decode from the latched byte
    always_comb
    begin
        if (mode_reg == MODE_TWO_BIT)
            pen = {2'b00, latched_next[{1'b0, ~sub}], latched_next[{1'b1, ~sub}]};
        else if (!sub[1])
            pen = {latched_next[1], latched_next[5], latched_next[3], latched_next[7]};
        else
            pen = {latched_next[0], latched_next[4], latched_next[2], latched_next[6]};
    end

    // color select and phase advance
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (req.payload.vsync_in)
        begin
            phase_next = PHASE_FIRST;
        end
        else
        begin
            phase_next = 3'(phase_reg + 3'd1);
            if (req.payload.display_enable)
                held_next = hw_color(pen_colors_reg[pen]);
            else
                held_next = hw_color(border_reg);
        end
    end

    // result for the accepted transaction
    always_comb
    begin
        push      = 1'b0;
        push_data = '0;
        if (accept)
        begin
            if (req.payload.req_type == REQ_PIXEL)
            begin
                push                  = 1'b1;
                push_data.result_kind = KIND_BEAM;
                push_data.pixel_color = held_next;
                push_data.hsync_out   = req.payload.hsync_in;
                push_data.vsync_out   = req.payload.vsync_in;
            end
            else if (cmd == CMD_MODE)
            begin
                push                        = 1'b1;
                push_data.result_kind       = KIND_MEM;
                push_data.lower_rom_enabled = !req.payload.io_data[2];
                push_data.upper_rom_enabled = !req.payload.io_data[3];
            end
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            latched_reg    <= '0;
            mode_reg       <= '0;
            chosen_pen_reg <= '0;
            border_reg     <= '0;
            held_reg       <= '0;
            for (int i = 0; i < 16; i++)
            begin
                pen_colors_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (req.payload.req_type == REQ_PIXEL)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                if (!req.payload.vsync_in)
                    latched_reg <= latched_next;
            end
            else
            begin
                unique case (cmd)
                    CMD_PEN_SEL: chosen_pen_reg <= req.payload.io_data[4:0];
                    CMD_PEN_SET:
                    begin
                        if (chosen_pen_reg[4])
                            border_reg <= req.payload.io_data[4:0];
                        else
                            pen_colors_reg[chosen_pen_reg[3:0]] <= req.payload.io_data[4:0];
                    end
                    CMD_MODE:    mode_reg <= req.payload.io_data[1:0];
                    default:     ;
                endcase
            end
        end
    end

    vpps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (res.payload)
    );

    // vsync pixel transaction restarts the phase
    a_vsync_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.payload.req_type == REQ_PIXEL && req.payload.vsync_in)
        |=> (phase_reg == PHASE_FIRST))
        else $error("phase not cleared by vsync");

    // active pixel transaction advances the phase by one
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.payload.req_type == REQ_PIXEL && !req.payload.vsync_in)
        |=> (phase_reg == 3'($past(phase_reg) + 3'd1)))
        else $error("phase did not advance");

    // bus transactions leave phase and held color alone
    a_bus_keeps_beam: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.payload.req_type == REQ_BUS)
        |=> ($stable(phase_reg) && $stable(held_reg)))
        else $error("bus transaction disturbed beam state");

endmodule

// ===== tb/palette_beam_checker.sv =====
`timescale 1ns / 100ps

module palette_beam_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  vpps_pkg::vpps_req_t req_item,
    input  logic                res_valid,
    input  logic                res_ready,
    input  vpps_pkg::vpps_res_t res_item,
    output int                  fail_count,
    output int                  pending
);
    import vpps_pkg::*;

    // fixed argb hardware colors, indexed by the 5-bit palette entry
    logic [31:0] argb_lut [0:31] = '{
        32'hff6B7D6E, 32'hff6D7D6E, 32'hff6BF300, 32'hff6DF3F3,
        32'hff6B0200, 32'hff6802F0, 32'hff687800, 32'hff6B7DF3,
        32'hff6802F3, 32'hff6BF3F3, 32'hff0DF3F3, 32'hffF9F3FF,
        32'hff0605F3, 32'hffF402F3, 32'hff0D7DF3, 32'hffF980FA,
        32'hff680200, 32'hff6BF302, 32'hff01F002, 32'hffF2F30F,
        32'hff010200, 32'hffF4020C, 32'hff017802, 32'hffF47B0C,
        32'hff680269, 32'hff6BF371, 32'hff04F571, 32'hffF4F371,
        32'hff01026C, 32'hffF2026C, 32'hff017B6E, 32'hffF67B6E
    };

    // shadow copy of the gate array state
    logic [2:0]  phase;
    logic [7:0]  shift_byte;
    logic [1:0]  mode;
    logic [4:0]  sel_pen;
    logic [4:0]  pen_table [0:15];
    logic [4:0]  border_pen;
    logic [31:0] beam_color;

    vpps_res_t pending_beam_q [$];

    // pen index for one pixel of the latched byte
    function automatic logic [3:0] pen_index(input logic [7:0] b, input logic [2:0] ph,
                                             input logic [1:0] md);
        logic [1:0] p;
        p = ph[1:0];
        if (md == MODE_TWO_BIT)
            return {2'b00, b[3 - p], b[7 - p]};
        if (p < 2'd2)
            return {b[1], b[5], b[3], b[7]};
        return {b[0], b[4], b[2], b[6]};
    endfunction

    // apply one accepted request to the shadow state, queue any result it causes
    task automatic advance_palette_model(input vpps_req_t rq);
        vpps_res_t r;
        logic [3:0] pen;
        r = '0;
        if (rq.req_type == REQ_BUS)
        begin
            case (vpps_cmd_t'(rq.io_data[7:6]))
                CMD_PEN_SEL: sel_pen = rq.io_data[4:0];
                CMD_PEN_SET:
                begin
                    if (sel_pen[4])
                        border_pen = rq.io_data[4:0];
                    else
                        pen_table[sel_pen[3:0]] = rq.io_data[4:0];
                end
                CMD_MODE:
                begin
                    mode = rq.io_data[1:0];
                    r.result_kind = KIND_MEM;
                    r.lower_rom_enabled = !rq.io_data[2];
                    r.upper_rom_enabled = !rq.io_data[3];
                    pending_beam_q.push_back(r);
                end
                default: ;
            endcase
        end
        else
        begin
            // vsync restarts the byte pair and freezes the beam color
            if (rq.vsync_in)
                phase = PHASE_FIRST;
            else
            begin
                if (phase == PHASE_FIRST)
                    shift_byte = rq.vram_byte_first;
                else if (phase == PHASE_SECOND)
                    shift_byte = rq.vram_byte_second;
                pen = pen_index(shift_byte, phase, mode);
                if (rq.display_enable)
                    beam_color = argb_lut[pen_table[pen]];
                else
                    beam_color = argb_lut[border_pen];
                phase = phase + 3'd1;
            end
            r.result_kind = KIND_BEAM;
            r.pixel_color = beam_color;
            r.hsync_out = rq.hsync_in;
            r.vsync_out = rq.vsync_in;
            pending_beam_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        vpps_res_t want;
        if (!rst_n)
        begin
            phase = '0;
            shift_byte = '0;
            mode = '0;
            sel_pen = '0;
            foreach (pen_table[i])
                pen_table[i] = '0;
            border_pen = '0;
            beam_color = '0;
            pending_beam_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // result transaction against the oldest expectation
            if (res_valid && res_ready)
            begin
                if (pending_beam_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with nothing expected: kind %0d color %h",
                                 $time, res_item.result_kind, res_item.pixel_color);
                end
                else
                begin
                    want = pending_beam_q.pop_front();
                    if (res_item.result_kind !== want.result_kind
                        || res_item.pixel_color !== want.pixel_color
                        || res_item.hsync_out !== want.hsync_out
                        || res_item.vsync_out !== want.vsync_out
                        || res_item.lower_rom_enabled !== want.lower_rom_enabled
                        || res_item.upper_rom_enabled !== want.upper_rom_enabled)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("%0t: mismatch kind %0d/%0d color %h/%h hsync %0d/%0d",
                                   $time, want.result_kind, res_item.result_kind,
                                   want.pixel_color, res_item.pixel_color,
                                   want.hsync_out, res_item.hsync_out);
                            $display(" vsync %0d/%0d lower %0d/%0d upper %0d/%0d (exp/got)",
                                     want.vsync_out, res_item.vsync_out,
                                     want.lower_rom_enabled, res_item.lower_rom_enabled,
                                     want.upper_rom_enabled, res_item.upper_rom_enabled);
                        end
                    end
                end
            end
            // request transaction updates the shadow state
            if (req_valid && req_ready)
                advance_palette_model(req_item);
            pending = pending_beam_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import vpps_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    bit hold_done;
    int quiet_cycles;

    vpps_stream_if #(.payload_t(vpps_req_t)) req_if ();
    vpps_stream_if #(.payload_t(vpps_res_t)) res_if ();

    video_pixel_palette_serializer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    palette_beam_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_if.valid),
        .req_ready  (req_if.ready),
        .req_item   (req_if.payload),
        .res_valid  (res_if.valid),
        .res_ready  (res_if.ready),
        .res_item   (res_if.payload),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beam side: random back pressure, plus one long hold-off on request
    initial
    begin
        res_if.ready = 1'b0;
        hold_done = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    res_if.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            @(negedge clk);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic vpps_req_t pixel_tick(input logic vs, input logic hs, input logic de,
                                             input logic [7:0] b0, input logic [7:0] b1);
        vpps_req_t rq;
        rq.req_type = REQ_PIXEL;
        rq.io_data = 8'($urandom);
        rq.vsync_in = vs;
        rq.hsync_in = hs;
        rq.display_enable = de;
        rq.vram_byte_first = b0;
        rq.vram_byte_second = b1;
        return rq;
    endfunction

    function automatic vpps_req_t bus_write(input vpps_cmd_t cmd, input logic [5:0] low);
        vpps_req_t rq;
        rq.req_type = REQ_BUS;
        rq.io_data = {cmd, low};
        rq.vsync_in = 1'($urandom);
        rq.hsync_in = 1'($urandom);
        rq.display_enable = 1'($urandom);
        rq.vram_byte_first = 8'($urandom);
        rq.vram_byte_second = 8'($urandom);
        return rq;
    endfunction

    // offer one transaction, with random sender gaps, and wait for its acceptance
    task automatic offer_tick(input vpps_req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering until every expected result has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // mostly well-formed scanline traffic with palette programming and some noise
    task automatic run_traffic(input int send_pct, input int recv_pct, input int quota,
                               input bit with_hold);
        int sent_here;
        int pick;
        int k;
        vpps_req_t rq;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent_here = 0;
        while (sent_here < quota)
        begin
            if (with_hold && sent_here >= quota / 2)
            begin
                with_hold = 1'b0;
                hold_off = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // one byte pair, eight pixels
                for (k = 0; k < 8; k++)
                    offer_tick(pixel_tick(1'b0, 1'($urandom), ($urandom_range(9) != 0),
                                          8'($urandom), 8'($urandom)));
                sent_here += 8;
            end
            else if (pick < 70)
            begin
                offer_tick(bus_write(CMD_PEN_SEL, 6'($urandom)));
                offer_tick(bus_write(CMD_PEN_SET, 6'($urandom)));
                sent_here += 2;
            end
            else if (pick < 78)
            begin
                offer_tick(bus_write(CMD_MODE, 6'($urandom)));
                sent_here += 1;
            end
            else if (pick < 88)
            begin
                // vertical sync, one to three ticks
                for (k = 0; k <= $urandom_range(2); k++)
                begin
                    offer_tick(pixel_tick(1'b1, 1'($urandom), 1'($urandom),
                                          8'($urandom), 8'($urandom)));
                    sent_here += 1;
                end
            end
            else
            begin
                // unstructured transaction, may break a byte pair
                rq.req_type = 1'($urandom);
                rq.io_data = 8'($urandom);
                rq.vsync_in = 1'($urandom);
                rq.hsync_in = 1'($urandom);
                rq.display_enable = 1'($urandom);
                rq.vram_byte_first = 8'($urandom);
                rq.vram_byte_second = 8'($urandom);
                offer_tick(rq);
                if (!(rq.req_type == REQ_BUS && rq.io_data[7:6] == CMD_NONE))
                    sent_here += 1;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int k;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        send_idle_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // untouched palette, all-ones byte
        offer_tick(pixel_tick(1'b0, 1'b1, 1'b1, 8'hFF, 8'h00));
        // pen 0 gets the top color, bit 5 of the data is dropped
        offer_tick(bus_write(CMD_PEN_SEL, 6'h00));
        offer_tick(bus_write(CMD_PEN_SET, 6'h3F));
        // pen 15, extra select bit ignored
        offer_tick(bus_write(CMD_PEN_SEL, 6'h2F));
        offer_tick(bus_write(CMD_PEN_SET, 6'h0B));
        // border select
        offer_tick(bus_write(CMD_PEN_SEL, 6'h10));
        offer_tick(bus_write(CMD_PEN_SET, 6'h14));
        // two-bit pens, both roms enabled
        offer_tick(bus_write(CMD_MODE, 6'h01));
        for (k = 0; k < 8; k++)
            offer_tick(pixel_tick(1'b0, k[0], (k != 5), 8'hA5, 8'h5A));
        // vsync holds the color and resets the phase
        offer_tick(pixel_tick(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF));
        // remaining modes with each rom bit combination
        offer_tick(bus_write(CMD_MODE, 6'h0E));
        offer_tick(bus_write(CMD_MODE, 6'h07));
        offer_tick(bus_write(CMD_MODE, 6'h08));
        // ignored command
        offer_tick(bus_write(CMD_NONE, 6'h3F));
        for (k = 0; k < 4; k++)
            offer_tick(pixel_tick(1'b0, 1'b0, 1'b1, 8'hFF, 8'h00));
        wait_drained();

        run_traffic(33, 55, 170, 1'b0);
        wait_drained();
        run_traffic(55, 33, 170, 1'b0);
        wait_drained();
        run_traffic(0, 0, 170, 1'b1);
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
